### rtl/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key/value cache
// Sizes of the entry store and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef struct packed {
    logic load;    // capture a request and restart the scan
    logic scan;    // issue one store read and advance the scan pointer
    logic commit;  // apply the update and load the result register
  } lkv_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last entry
    logic out_free;   // result register can take a beat this cycle
  } lkv_sts_t;

endpackage

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU eviction
// Get and set requests against a 16-entry store; sets report evictions.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries action_i, lookup_key_i and
//   write_value_i. Response channel (out_valid_o/out_ready_i) returns one beat
//   per request: found_o, read_value_o, evicted_o, evicted_key_o.
//   capacity_limit_we_i/capacity_limit_i write the entry limit; write it only
//   while no request is in flight. Zero acts as one, values above the store
//   size clip to it.
//   Timing: one request at a time. After the accepting edge the controller
//   walks all CAPACITY entries through the key/value RAM read port (one entry
//   per cycle), spends a drain state on the last compare and a commit state on
//   the update, which loads the response register; a new request is taken
//   only once the controller is back in idle.
//   Receiver stall: a pending response sits in the output register while the
//   next request is accepted and scanned; its commit waits until that
//   register drains.
//   Reset: the store is empty (all valid bits and ranks clear, count zero),
//   the limit returns to 16 and no response is pending. Key and value RAMs
//   are not cleared; only valid entries are ever used.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               capacity_limit_we_i,
  input  logic [lkv_pkg::CFG_W-1:0]          capacity_limit_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]  lookup_key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]  write_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic signed [lkv_pkg::DATA_W-1:0]  read_value_o,
  output logic                               evicted_o,
  output logic signed [lkv_pkg::DATA_W-1:0]  evicted_key_o
);

  lkv_pkg::lkv_cmd_t cmd;
  lkv_pkg::lkv_sts_t sts;

  // sequencer: idle, scan, last compare, commit
  lkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, trackers, rank update and response register
  lkv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (capacity_limit_we_i),
    .cfg_wdata_i   (capacity_limit_i),
    .action_i      (action_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

  // An accepted request keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while a scan was starting");

  // A commit always presents a response beat on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit did not load the response register");

  // An eviction only comes from a set that missed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> (!found_o && (read_value_o == -32'sd1)))
    else $error("eviction reported on a hit or a get");

  // No eviction means the evicted key reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evicted_o) |-> (evicted_key_o == 32'sd0))
    else $error("evicted key set without an eviction");

endmodule

### rtl/lkv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl: request sequencer
// Accept a request, walk the store, then commit once the result register
// has room.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lkv_pkg::lkv_sts_t sts_i,
  output lkv_pkg::lkv_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StCommit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      // last compare lands here
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/lkv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_dp: entry store, scan trackers, recency ranks and result register
// Keys and values sit in RAM; valid bits, ranks and the count in flops.
// ----------------------------------------------------------------------------
module lkv_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lkv_pkg::lkv_cmd_t                   cmd_i,
  output lkv_pkg::lkv_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [lkv_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                action_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]   lookup_key_i,
  input  logic signed [lkv_pkg::DATA_W-1:0]   write_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic signed [lkv_pkg::DATA_W-1:0]   read_value_o,
  output logic                                evicted_o,
  output logic signed [lkv_pkg::DATA_W-1:0]   evicted_key_o
);

  localparam int unsigned IW = lkv_pkg::IDX_W;
  localparam int unsigned DW = lkv_pkg::DATA_W;
  localparam int unsigned NE = lkv_pkg::CAPACITY;

  // request
  logic          act_q;
  logic [DW-1:0] key_q, wval_q;
  logic [lkv_pkg::CFG_W-1:0] cfg_q;

  // scan
  logic [IW-1:0] addr_q, addr_d;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic [DW-1:0] key_rd, val_rd;

  // trackers
  logic          hit_q, free_found_q, lru_found_q;
  logic [IW-1:0] hit_idx_q, hit_rank_q, free_idx_q, lru_idx_q, lru_rank_q;
  logic [DW-1:0] hit_val_q, lru_key_q;

  // entry state
  logic             valid_q [NE];
  logic             valid_d [NE];
  logic [IW-1:0]    rank_q  [NE];
  logic [IW-1:0]    rank_d  [NE];
  logic [lkv_pkg::CNT_W-1:0] count_q, count_d;

  // result register
  logic          out_valid_q;
  logic          found_q, evicted_q;
  logic [DW-1:0] read_value_q, evicted_key_q;

  // commit decode
  logic [31:0]   cfg_ext, cnt_ext, lim_ext;
  logic          at_limit, evict, ins_ok, cmp_v, cmp_match;
  logic [IW-1:0] slot, cmp_rank;

  assign sts_o.scan_last = (addr_q == IW'(NE - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = '0;
    end else if (cmd_i.scan) begin
      addr_d = addr_q + IW'(1);
    end
  end

  lkv_ram #(.WIDTH(DW), .DEPTH(NE)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && ins_ok),
    .waddr_i (slot),
    .wdata_i (key_q),
    .re_i    (cmd_i.scan),
    .raddr_i (addr_q),
    .rdata_o (key_rd)
  );

  lkv_ram #(.WIDTH(DW), .DEPTH(NE)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && (act_q == lkv_pkg::ACT_SET) && (hit_q || ins_ok)),
    .waddr_i (hit_q ? hit_idx_q : slot),
    .wdata_i (wval_q),
    .re_i    (cmd_i.scan),
    .raddr_i (addr_q),
    .rdata_o (val_rd)
  );

  assign cmp_v     = valid_q[cmp_idx_q];
  assign cmp_rank  = rank_q[cmp_idx_q];
  assign cmp_match = cmp_v && (key_rd == key_q);

  // effective limit: zero acts as one, large values clip to the store size
  always_comb begin
    cfg_ext = 32'(cfg_q);
    cnt_ext = 32'(count_q);
    if (cfg_ext == 32'd0) begin
      lim_ext = 32'd1;
    end else if (cfg_ext > 32'(NE)) begin
      lim_ext = 32'(NE);
    end else begin
      lim_ext = cfg_ext;
    end
  end

  assign at_limit = (cnt_ext >= lim_ext);
  assign evict    = (act_q == lkv_pkg::ACT_SET) && !hit_q && at_limit && lru_found_q;
  assign ins_ok   = (act_q == lkv_pkg::ACT_SET) && !hit_q && (evict || free_found_q);

  // first free slot after the eviction
  always_comb begin
    slot = free_idx_q;
    if (evict && !(free_found_q && (free_idx_q < lru_idx_q))) begin
      slot = lru_idx_q;
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < NE; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
    end
    if (cmd_i.commit && (act_q == lkv_pkg::ACT_SET)) begin
      if (hit_q) begin
        for (int i = 0; i < NE; i++) begin
          if (IW'(i) == hit_idx_q) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
      end else if (ins_ok) begin
        for (int i = 0; i < NE; i++) begin
          if (IW'(i) == slot) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (evict && (IW'(i) == lru_idx_q)) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        if (!evict) begin
          count_d = count_q + lkv_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= lkv_pkg::CFG_RESET;
      addr_q       <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      lru_found_q  <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NE; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      addr_q    <= addr_d;
      cmp_vld_q <= cmd_i.scan;
      count_q   <= count_d;
      for (int i = 0; i < NE; i++) begin
        valid_q[i] <= valid_d[i];
        rank_q[i]  <= rank_d[i];
      end
      if (cmd_i.load) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        lru_found_q  <= 1'b0;
      end else if (cmp_vld_q) begin
        if (cmp_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!cmp_v && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (cmp_v) begin
          lru_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      key_q  <= $unsigned(lookup_key_i);
      wval_q <= $unsigned(write_value_i);
    end
    cmp_idx_q <= addr_q;
    if (cmp_vld_q && !cmd_i.load) begin
      if (cmp_match && !hit_q) begin
        hit_idx_q  <= cmp_idx_q;
        hit_rank_q <= cmp_rank;
        hit_val_q  <= val_rd;
      end
      if (!cmp_v && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cmp_v && (!lru_found_q || (cmp_rank > lru_rank_q))) begin
        lru_idx_q  <= cmp_idx_q;
        lru_rank_q <= cmp_rank;
        lru_key_q  <= key_rd;
      end
    end
    if (cmd_i.commit) begin
      found_q       <= hit_q;
      read_value_q  <= ((act_q == lkv_pkg::ACT_GET) && hit_q) ? hit_val_q : '1;
      evicted_q     <= evict;
      evicted_key_q <= evict ? lru_key_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign read_value_o  = $signed(read_value_q);
  assign evicted_o     = evicted_q;
  assign evicted_key_o = $signed(evicted_key_q);

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU key/value cache
// Drives get and set beats through the request channel and checks every
// response beat against the bench's shadow LRU store or, where a row gives
// one, a response typed into the directed table. That short table of
// requests and capacity changes runs first. Then come random segments, each
// with its own entry limit and key pool, under three backpressure profiles.
// ----------------------------------------------------------------------------
module testbench;
  import lkv_pkg::*;

  // One response beat as the bench predicts and samples it.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } cache_response_t;

  typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_e;

  // One line of the directed table: a request, or a write of the entry limit.
  // Where known_rsp is set, rsp is the response read straight off the spec.
  // Otherwise the shadow store supplies the expected response.
  typedef struct {
    row_kind_e         kind;
    logic [CFG_W-1:0]  limit;
    logic              act;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    bit                known_rsp;
    cache_response_t   rsp;
  } stim_row_t;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;  // read value on a miss or a set
  localparam cache_response_t MISS_RSP =
    '{found: 1'b0, read_value: MISS_VALUE, evicted: 1'b0, evicted_key: '0};
  localparam cache_response_t NO_RSP = '0;
  localparam int DRAIN_CYCLES = CAPACITY + 8;
  localparam int SEGMENT_ITEMS = 100;
  localparam int NUM_SEGMENTS = 12;

  // Directed table. Walk it in order; each limit row waits for the block to go
  // idle before the write.
  stim_row_t directed_rows [26] = '{
    // Empty store after reset: a get misses.
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS_RSP},
    // Insert the extreme keys with extreme values.
    '{ROW_REQUEST, '0, ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, MISS_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
      cache_response_t'{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
    '{ROW_REQUEST, '0, ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, MISS_RSP},
    // Set of a present key: found, read value stays -1, no eviction.
    '{ROW_REQUEST, '0, ACT_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      cache_response_t'{1'b1, MISS_VALUE, 1'b0, 32'h0}},
    // The get ignores write_value.
    '{ROW_REQUEST, '0, ACT_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1,
      cache_response_t'{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_REQUEST, '0, ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
      cache_response_t'{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    // Lower the limit below the count: each new key evicts one, count holds.
    '{ROW_LIMIT,   5'd1, ACT_GET, '0, '0, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0005, 32'h0000_0005, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0006, 32'h0000_0006, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, NO_RSP},
    // Zero limit behaves as one.
    '{ROW_LIMIT,   5'd0, ACT_GET, '0, '0, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, NO_RSP},
    // Limit above the store size clips to the store size.
    '{ROW_LIMIT,   5'd31, ACT_GET, '0, '0, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0002, 32'h5A5A_5A5A, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, NO_RSP},
    // Small limit: an update refreshes recency and moves the victim.
    '{ROW_LIMIT,   5'd2, ACT_GET, '0, '0, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0003, 32'h0000_0003, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0004, 32'h0000_0004, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_SET, 32'h0000_0003, 32'h0000_0033, 1'b0, NO_RSP},
    '{ROW_REQUEST, '0, ACT_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, NO_RSP}
  };

  // Entry limit of each random segment; the extremes and both special
  // cases (zero, above the store size) are among them.
  logic [CFG_W-1:0] segment_limits [NUM_SEGMENTS] =
    '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd5, 5'd12, 5'd4, 5'd16};

  // DUT inputs, all known from time zero.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              capacity_limit_we_i = 1'b0;
  logic [CFG_W-1:0]  capacity_limit_i = CFG_RESET;
  logic              in_valid_i = 1'b0;
  logic              action_i = ACT_GET;
  logic [DATA_W-1:0] lookup_key_i = '0;
  logic [DATA_W-1:0] write_value_i = '0;
  logic              out_ready_i = 1'b0;

  logic              in_ready_o;
  logic              out_valid_o;
  logic              found_o;
  logic [DATA_W-1:0] read_value_o;
  logic              evicted_o;
  logic [DATA_W-1:0] evicted_key_o;

  // Side channel that travels with the request beat: a response typed into
  // the directed table, to be used in place of the shadow store's one.
  bit              req_known_rsp = 1'b0;
  cache_response_t req_rsp = '0;

  // Shadow store of the cache.
  logic [DATA_W-1:0] shadow_keys   [CAPACITY];
  logic [DATA_W-1:0] shadow_values [CAPACITY];
  bit                shadow_valid  [CAPACITY] = '{default: 1'b0};
  logic [3:0]        shadow_rank   [CAPACITY] = '{default: 4'd0};
  logic [CNT_W-1:0]  shadow_count = '0;
  logic [CFG_W-1:0]  shadow_limit = CFG_RESET;

  cache_response_t pending_responses [$];
  int requests_sent = 0;
  int responses_checked = 0;
  int error_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  lru_key_value_cache u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .capacity_limit_we_i(capacity_limit_we_i),
    .capacity_limit_i   (capacity_limit_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .lookup_key_i       (lookup_key_i),
    .write_value_i      (write_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .found_o            (found_o),
    .read_value_o       (read_value_o),
    .evicted_o          (evicted_o),
    .evicted_key_o      (evicted_key_o)
  );

  always #4 clk_i = ~clk_i;

  // Advance the shadow store by one request and return the response it owes.
  function automatic cache_response_t predict_cache_response(
    input logic act, input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] value
  );
    cache_response_t rsp;
    int hit;
    int victim;
    int slot;
    logic [CNT_W-1:0] eff_limit;
    logic [3:0] old_rank;
    rsp = MISS_RSP;
    hit = -1;
    victim = -1;
    slot = -1;
    // Zero acts as one; anything above the store size clips to it.
    if (shadow_limit == 0) eff_limit = CNT_W'(1);
    else if (shadow_limit > CAPACITY) eff_limit = CNT_W'(CAPACITY);
    else eff_limit = CNT_W'(shadow_limit);
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_keys[i] == key) hit = i;
    end
    rsp.found = (hit >= 0);
    if (act == ACT_GET) begin
      // A get never touches recency.
      if (hit >= 0) rsp.read_value = shadow_values[hit];
    end else if (hit >= 0) begin
      // Update in place; entries newer than the hit age by one.
      shadow_values[hit] = value;
      old_rank = shadow_rank[hit];
      for (int i = 0; i < CAPACITY; i++) begin
        if (shadow_valid[i] && i != hit && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[hit] = '0;
    end else begin
      // New key: drop the oldest entry first when the store is at or over its limit.
      if (shadow_count >= eff_limit && shadow_count > 0) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim])) begin
            victim = i;
          end
        end
        if (victim >= 0) begin
          rsp.evicted = 1'b1;
          rsp.evicted_key = shadow_keys[victim];
          shadow_valid[victim] = 1'b0;
          shadow_rank[victim] = '0;
          shadow_count--;
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_valid[i]) shadow_rank[i]++;
        end
        shadow_valid[slot] = 1'b1;
        shadow_keys[slot] = key;
        shadow_values[slot] = value;
        shadow_rank[slot] = '0;
        shadow_count++;
      end
    end
    return rsp;
  endfunction

  function automatic void report_mismatch(
    input string field, input logic [DATA_W-1:0] expected, input logic [DATA_W-1:0] actual
  );
    $error("%s: expected %h, got %h", field, expected, actual);
    error_count++;
  endfunction

  // Single sampling point for both channels and the limit register. Handle
  // the request side before the response side so a beat is always predicted
  // before anything could be compared against it.
  always @(posedge clk_i) begin
    cache_response_t predicted;
    cache_response_t expected;
    if (rst_ni) begin
      if (capacity_limit_we_i) shadow_limit = capacity_limit_i;
      if (in_valid_i && in_ready_o) begin
        predicted = predict_cache_response(action_i, lookup_key_i, write_value_i);
        pending_responses.push_back(req_known_rsp ? req_rsp : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        responses_checked++;
        if (pending_responses.size() == 0) begin
          $error("response beat with no request outstanding");
          error_count++;
        end else begin
          expected = pending_responses.pop_front();
          if (found_o !== expected.found)
            report_mismatch("found", DATA_W'(expected.found), DATA_W'(found_o));
          if (read_value_o !== expected.read_value)
            report_mismatch("read_value", expected.read_value, read_value_o);
          if (evicted_o !== expected.evicted)
            report_mismatch("evicted", DATA_W'(expected.evicted), DATA_W'(evicted_o));
          if (evicted_key_o !== expected.evicted_key)
            report_mismatch("evicted_key", expected.evicted_key, evicted_key_o);
        end
      end
    end
  end

  // Response side backpressure: stall at the current percentage, per cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Present one request beat after an optional random gap and hold it until
  // accepted. Valid stays high into the next call unless that call idles.
  task automatic send_request(
    input logic act, input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] value,
    input bit known, input cache_response_t rsp
  );
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    lookup_key_i  <= key;
    write_value_i <= value;
    req_known_rsp <= known;
    req_rsp       <= rsp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drop valid, wait for every response beat, then let the block settle.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (responses_checked < requests_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity_limit(input logic [CFG_W-1:0] limit);
    wait_until_idle();
    capacity_limit_we_i <= 1'b1;
    capacity_limit_i    <= limit;
    @(posedge clk_i);
    capacity_limit_we_i <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] key_pool [$];
    logic [DATA_W-1:0] key;
    logic act;
    int eff;
    int pool_size;
    int pick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: sender idles often, receiver stalls most of the time.
    sender_idle_pct = 29;
    receiver_idle_pct = 78;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LIMIT) begin
        write_capacity_limit(directed_rows[i].limit);
      end else begin
        send_request(directed_rows[i].act, directed_rows[i].key, directed_rows[i].value,
                     directed_rows[i].known_rsp, directed_rows[i].rsp);
      end
    end

    // Random segments: first third with the sender sparse and the receiver
    // stalling, second third the other way round, last third at full rate.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      write_capacity_limit(segment_limits[seg]);
      if (seg < NUM_SEGMENTS / 3) begin
        sender_idle_pct = 29;
        receiver_idle_pct = 78;
      end else if (seg < 2 * NUM_SEGMENTS / 3) begin
        sender_idle_pct = 78;
        receiver_idle_pct = 29;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end

      // Size the key pool a little past the limit so that hits, updates and
      // evictions all stay frequent.
      if (segment_limits[seg] == 0) eff = 1;
      else if (segment_limits[seg] > CAPACITY) eff = int'(CAPACITY);
      else eff = int'(segment_limits[seg]);
      pool_size = $urandom_range(eff + 6, eff + 1);
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(9))
          0: key_pool.push_back(32'h8000_0000);
          1: key_pool.push_back(32'h7FFF_FFFF);
          2: key_pool.push_back(32'hFFFF_FFFF);
          3: key_pool.push_back(32'h0000_0000);
          default: key_pool.push_back($urandom);
        endcase
      end

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          // Noise: a fresh key that is almost surely absent.
          key = $urandom;
          act = $urandom_range(1) ? ACT_SET : ACT_GET;
        end else begin
          key = key_pool[$urandom_range(key_pool.size() - 1)];
          act = ($urandom_range(99) < 55) ? ACT_SET : ACT_GET;
        end
        send_request(act, key, $urandom, 1'b0, NO_RSP);
      end
    end

    wait_until_idle();
    if (pending_responses.size() != 0) begin
      $error("%0d response beats never arrived", pending_responses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
